// ===== design/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and types of the COBS frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int RAW_SLACK   = 8;
  localparam int RAW_LIMIT   = MAX_PAYLOAD + RAW_SLACK;
  localparam int CNT_W       = $clog2(RAW_LIMIT + 1);
  localparam int LEN_W       = 16;
  localparam int CMP_W       = LEN_W + 1;
  localparam int BODY_EXTRA  = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CODE_FULL = 8'hff;
  localparam logic [7:0] DELIM     = 8'h00;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [1:0] {
    EV_DATA,
    EV_END,
    EV_RESTART
  } ev_kind_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EMPTY,
    ST_SHORT,
    ST_BAD_LEN,
    ST_BAD_SUM
  } status_e;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] data;
    logic       empty;
  } event_t;

endpackage

// ===== design/cfr_front.sv =====
// ----------------------------------------------------------------------------
// cfr_front
// Accepts raw link bytes, tracks COBS groups and raw length, and turns its
// bytes into decoded-body events for the back end.
// ----------------------------------------------------------------------------
module cfr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     raw_byte_i,
  input  logic           q_full_i,
  output logic           push_o,
  output cfr_pkg::event_t push_ev_o
);
  import cfr_pkg::*;

  logic [CNT_W-1:0] raw_cnt_q, raw_cnt_d;
  logic [7:0]       group_q, group_d;
  logic             last_full_q, last_full_d;
  logic             accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    raw_cnt_d       = raw_cnt_q;
    group_d         = group_q;
    last_full_d     = last_full_q;
    push_o          = 1'b0;
    push_ev_o.kind  = EV_DATA;
    push_ev_o.data  = raw_byte_i;
    push_ev_o.empty = (raw_cnt_q == '0);
    if (accept) begin
      if (raw_byte_i == DELIM) begin
        push_o         = 1'b1;
        push_ev_o.kind = EV_END;
        raw_cnt_d      = '0;
        group_d        = '0;
        last_full_d    = 1'b1;
      end else if (raw_cnt_q >= CNT_W'(RAW_LIMIT)) begin
        push_o         = 1'b1;
        push_ev_o.kind = EV_RESTART;
        raw_cnt_d      = '0;
        group_d        = '0;
        last_full_d    = 1'b1;
      end else begin
        raw_cnt_d = raw_cnt_q + CNT_W'(1);
        if (group_q != '0) begin
          group_d = group_q - 8'd1;
          push_o  = 1'b1;
        end else begin
          push_o         = !last_full_q;
          push_ev_o.data = 8'h00;
          last_full_d    = (raw_byte_i == CODE_FULL);
          group_d        = raw_byte_i - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_cnt_q   <= '0;
      group_q     <= '0;
      last_full_q <= 1'b1;
    end else begin
      raw_cnt_q   <= raw_cnt_d;
      group_q     <= group_d;
      last_full_q <= last_full_d;
    end
  end

endmodule

// ===== design/cfr_queue.sv =====
// ----------------------------------------------------------------------------
// cfr_queue
// Short event queue between the front and back ends.
// ----------------------------------------------------------------------------
module cfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cfr_pkg::event_t push_ev_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output cfr_pkg::event_t head_o
);
  import cfr_pkg::*;

  event_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/cfr_back.sv =====
// ----------------------------------------------------------------------------
// cfr_back
// Consumes decoded-body events: holds header, sums the body, emits payload
// words and frame-end status through a registered output stage.
// ----------------------------------------------------------------------------
module cfr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  cfr_pkg::event_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            result_kind_o,
  output logic [7:0]      payload_index_o,
  output logic [7:0]      payload_value_o,
  output logic [2:0]      frame_status_o,
  output logic [7:0]      frame_command_o,
  output logic [15:0]     frame_length_o
);
  import cfr_pkg::*;

  logic [CNT_W-1:0] dec_cnt_q, dec_cnt_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       run_sum_q, run_sum_d;
  logic [7:0]       rcv_sum_q, rcv_sum_d;

  logic             out_valid_q;
  logic             kind_q, kind_d;
  logic [7:0]       idx_q, idx_d;
  logic [7:0]       val_q, val_d;
  status_e          status_q, status_d;
  logic [7:0]       ocmd_q, ocmd_d;
  logic [LEN_W-1:0] olen_q, olen_d;

  logic             slot_free;
  logic             gen;
  logic [CNT_W-1:0] pos;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = !empty_i && slot_free;
  assign pos       = dec_cnt_q - CNT_W'(3);

  always_comb begin
    dec_cnt_d = dec_cnt_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    run_sum_d = run_sum_q;
    rcv_sum_d = rcv_sum_q;
    gen       = 1'b0;
    kind_d    = KIND_PAYLOAD;
    idx_d     = '0;
    val_d     = '0;
    status_d  = ST_OK;
    ocmd_d    = '0;
    olen_d    = '0;
    if (pop_o) begin
      unique case (head_i.kind)
        EV_DATA: begin
          run_sum_d = run_sum_q + rcv_sum_q;
          rcv_sum_d = head_i.data;
          dec_cnt_d = dec_cnt_q + CNT_W'(1);
          if (dec_cnt_q == CNT_W'(0)) begin
            cmd_d = head_i.data;
          end else if (dec_cnt_q == CNT_W'(1)) begin
            len_d = {len_q[15:8], head_i.data};
          end else if (dec_cnt_q == CNT_W'(2)) begin
            len_d = {head_i.data, len_q[7:0]};
          end else if ((CMP_W'(pos) < CMP_W'(len_q)) && (pos < CNT_W'(MAX_PAYLOAD))) begin
            gen   = 1'b1;
            idx_d = pos[7:0];
            val_d = head_i.data;
          end
        end
        EV_END: begin
          gen    = 1'b1;
          kind_d = KIND_END;
          ocmd_d = cmd_q;
          olen_d = len_q;
          if (head_i.empty) begin
            status_d = ST_EMPTY;
          end else if (dec_cnt_q < CNT_W'(BODY_EXTRA)) begin
            status_d = ST_SHORT;
          end else if ((len_q > LEN_W'(MAX_PAYLOAD)) ||
                       (CMP_W'(dec_cnt_q) != CMP_W'(len_q) + CMP_W'(BODY_EXTRA))) begin
            status_d = ST_BAD_LEN;
          end else if (run_sum_q != rcv_sum_q) begin
            status_d = ST_BAD_SUM;
          end
          dec_cnt_d = '0;
          cmd_d     = '0;
          len_d     = '0;
          run_sum_d = '0;
          rcv_sum_d = '0;
        end
        EV_RESTART: begin
          dec_cnt_d = '0;
          cmd_d     = '0;
          len_d     = '0;
          run_sum_d = '0;
          rcv_sum_d = '0;
        end
        default: begin
          dec_cnt_d = dec_cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_cnt_q   <= '0;
      cmd_q       <= '0;
      len_q       <= '0;
      run_sum_q   <= '0;
      rcv_sum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dec_cnt_q <= dec_cnt_d;
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      run_sum_q <= run_sum_d;
      rcv_sum_q <= rcv_sum_d;
      if (slot_free) begin
        out_valid_q <= pop_o && gen;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && gen) begin
      kind_q   <= kind_d;
      idx_q    <= idx_d;
      val_q    <= val_d;
      status_q <= status_d;
      ocmd_q   <= ocmd_d;
      olen_q   <= olen_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign payload_index_o = idx_q;
  assign payload_value_o = val_q;
  assign frame_status_o  = 3'(status_q);
  assign frame_command_o = ocmd_q;
  assign frame_length_o  = olen_q;

endmodule

// ===== design/cobs_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// cobs_frame_receiver
// Streaming COBS unstuffer and frame checker: payload words as decoded,
// one status word per delimiter.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid_i / in_stall_o   raw_byte_i
//  out      out_valid_o / out_stall_i result_kind_o, payload_index_o,
//                                     payload_value_o, frame_status_o,
//                                     frame_command_o, frame_length_o
//
//  One raw byte per cycle sustained while in_stall_o is low; a word passes the event queue, then the output register.
//  Front end unstuffs into a two-entry event queue; back end drains it.
//  in_stall_o rises only when the queue is full, i.e. the output stalls.
//  Reset clears all frame state at once; no clearing pass.
// ----------------------------------------------------------------------------
module cobs_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  raw_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_index_o,
  output logic [7:0]  payload_value_o,
  output logic [2:0]  frame_status_o,
  output logic [7:0]  frame_command_o,
  output logic [15:0] frame_length_o
);
  import cfr_pkg::*;

  logic   push, q_full, q_empty, pop;
  event_t push_ev, head_ev;

  cfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .raw_byte_i (raw_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_ev_o  (push_ev)
  );

  cfr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_ev_i (push_ev),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .head_o    (head_ev)
  );

  cfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .head_i          (head_ev),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .payload_index_o (payload_index_o),
    .payload_value_o (payload_value_o),
    .frame_status_o  (frame_status_o),
    .frame_command_o (frame_command_o),
    .frame_length_o  (frame_length_o)
  );

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue full and empty together");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_PAYLOAD) |->
      (frame_status_o == 3'(ST_OK) && frame_command_o == 8'h00 &&
       frame_length_o == 16'h0000))
    else $error("payload word carries frame fields");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_END && frame_status_o == 3'(ST_EMPTY)) |->
      (frame_command_o == 8'h00 && frame_length_o == 16'h0000))
    else $error("empty frame reports header");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(result_kind_o) && $stable(payload_index_o) &&
       $stable(payload_value_o) && $stable(frame_status_o)))
    else $error("stalled output word changed");

endmodule
